@@ rtl/core/basic_lexical_tokenizer_assert.svh @@
// Assertion macros for the BASIC lexical tokenizer.
`ifndef BASIC_LEXICAL_TOKENIZER_ASSERT_SVH
`define BASIC_LEXICAL_TOKENIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BLT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BLT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/blt_pkg.sv @@
// Package: token codes, lexer modes, keyword ROM and character classes.
`timescale 1ns / 1ps
package blt_pkg;
    localparam int MAX_KEYWORD_LENGTH_DEF = 9;
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int NUM_KEYWORDS = 87;
    localparam int KW_ROM_LEN = 9;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [3:0] K_END = 4'd0;
    localparam logic [3:0] K_EOL = 4'd1;
    localparam logic [3:0] K_INT = 4'd2;
    localparam logic [3:0] K_REAL = 4'd3;
    localparam logic [3:0] K_STR = 4'd4;
    localparam logic [3:0] K_TYPED = 4'd5;
    localparam logic [3:0] K_UNTYPED = 4'd6;
    localparam logic [3:0] K_KEY = 4'd7;
    localparam logic [3:0] K_SYM = 4'd8;
    localparam logic [3:0] K_ERR = 4'd9;

    localparam logic [1:0] E_NONE = 2'd0;
    localparam logic [1:0] E_CHAR = 2'd1;
    localparam logic [1:0] E_NEWLINE = 2'd2;
    localparam logic [1:0] E_UNTERM = 2'd3;

    localparam logic [4:0] S_LT = 5'd5;
    localparam logic [4:0] S_LE = 5'd6;
    localparam logic [4:0] S_GT = 5'd7;
    localparam logic [4:0] S_GE = 5'd8;
    localparam logic [4:0] S_NE = 5'd10;
    localparam logic [4:0] S_DOT = 5'd16;
    localparam logic [4:0] S_NONE = 5'd31;

    typedef enum logic [3:0] {
        M_IDLE, M_WS, M_COMMENT, M_INT, M_REAL, M_STR, M_NAME, M_SYM
    } mode_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [6:0] kw;
        logic [4:0] sym;
        logic [1:0] err;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
    } token_t;

    typedef logic [KW_ROM_LEN*8-1:0] kw_word_t;

    function automatic kw_word_t kw_str(input string s);
        kw_word_t w;
        w = '0;
        for (int i = 0; i < KW_ROM_LEN; i++) begin
            if (i < s.len()) w[i*8 +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic kw_word_t kw_rom(input logic [6:0] i);
        case (i)
            7'd0: return kw_str("ABS");       7'd1: return kw_str("AND");
            7'd2: return kw_str("AS");        7'd3: return kw_str("ASC");
            7'd4: return kw_str("ATN");       7'd5: return kw_str("BIN$");
            7'd6: return kw_str("BOOLEAN");   7'd7: return kw_str("CALL");
            7'd8: return kw_str("CASE");      7'd9: return kw_str("CHR$");
            7'd10: return kw_str("COMMAND$"); 7'd11: return kw_str("CONST");
            7'd12: return kw_str("COS");      7'd13: return kw_str("DATA");
            7'd14: return kw_str("DATE$");    7'd15: return kw_str("DECLARE");
            7'd16: return kw_str("DIM");      7'd17: return kw_str("DO");
            7'd18: return kw_str("ELSE");     7'd19: return kw_str("ELSEIF");
            7'd20: return kw_str("END");      7'd21: return kw_str("ENVIRON$");
            7'd22: return kw_str("EXIT");     7'd23: return kw_str("EXP");
            7'd24: return kw_str("FALSE");    7'd25: return kw_str("FIX");
            7'd26: return kw_str("FOR");      7'd27: return kw_str("FUNCTION");
            7'd28: return kw_str("GOSUB");    7'd29: return kw_str("HEX$");
            7'd30: return kw_str("IF");       7'd31: return kw_str("INKEY$");
            7'd32: return kw_str("INPUT");    7'd33: return kw_str("INSTR");
            7'd34: return kw_str("INT");      7'd35: return kw_str("INTEGER");
            7'd36: return kw_str("IS");       7'd37: return kw_str("LBOUND");
            7'd38: return kw_str("LCASE$");   7'd39: return kw_str("LEFT$");
            7'd40: return kw_str("LEN");      7'd41: return kw_str("LOG");
            7'd42: return kw_str("LOOP");     7'd43: return kw_str("LTRIM$");
            7'd44: return kw_str("MID$");     7'd45: return kw_str("MOD");
            7'd46: return kw_str("NEXT");     7'd47: return kw_str("NOT");
            7'd48: return kw_str("OCT$");     7'd49: return kw_str("OR");
            7'd50: return kw_str("PRINT");    7'd51: return kw_str("RANDOMIZE");
            7'd52: return kw_str("READ");     7'd53: return kw_str("REAL");
            7'd54: return kw_str("REDIM");    7'd55: return kw_str("RESTORE");
            7'd56: return kw_str("RETURN");   7'd57: return kw_str("RIGHT$");
            7'd58: return kw_str("RND");      7'd59: return kw_str("RTRIM$");
            7'd60: return kw_str("SELECT");   7'd61: return kw_str("SHARED");
            7'd62: return kw_str("SGN");      7'd63: return kw_str("SIN");
            7'd64: return kw_str("SLEEP");    7'd65: return kw_str("SPACE$");
            7'd66: return kw_str("SQR");      7'd67: return kw_str("STATIC");
            7'd68: return kw_str("STEP");     7'd69: return kw_str("STR$");
            7'd70: return kw_str("STRING");   7'd71: return kw_str("STRING$");
            7'd72: return kw_str("SUB");      7'd73: return kw_str("SWAP");
            7'd74: return kw_str("TAN");      7'd75: return kw_str("TIME$");
            7'd76: return kw_str("TIMER");    7'd77: return kw_str("THEN");
            7'd78: return kw_str("TO");       7'd79: return kw_str("TRUE");
            7'd80: return kw_str("TYPE");     7'd81: return kw_str("UBOUND");
            7'd82: return kw_str("UCASE$");   7'd83: return kw_str("UNTIL");
            7'd84: return kw_str("VAL");      7'd85: return kw_str("WHILE");
            7'd86: return kw_str("XOR");
            default: return '0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction
    function automatic logic is_suffix(input logic [7:0] c);
        return c == 8'h3F || c == 8'h25 || c == 8'h21 || c == 8'h24;
    endfunction
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [4:0] single_symbol(input logic [7:0] c);
        case (c)
            8'h2B: return 5'd0;   8'h2D: return 5'd1;
            8'h2A: return 5'd2;   8'h2F: return 5'd3;
            8'h5C: return 5'd4;   8'h3C: return S_LT;
            8'h3E: return S_GT;   8'h3D: return 5'd9;
            8'h3A: return 5'd11;  8'h2C: return 5'd12;
            8'h3B: return 5'd13;  8'h28: return 5'd14;
            8'h29: return 5'd15;  8'h2E: return S_DOT;
            default: return S_NONE;
        endcase
    endfunction
endpackage

@@ rtl/core/blt_kw_match.sv @@
// Keyword matcher: parallel compare of the open name against the keyword ROM.
`timescale 1ns / 1ps
module blt_kw_match #(
    parameter int MAX_KEYWORD_LENGTH = blt_pkg::MAX_KEYWORD_LENGTH_DEF
) (
    input  logic [MAX_KEYWORD_LENGTH*8-1:0] name_chars,
    input  logic [15:0]                     name_len,
    output logic                            hit,
    output logic [6:0]                      index
);
    import blt_pkg::*;
    localparam int CMP = (MAX_KEYWORD_LENGTH < KW_ROM_LEN) ? MAX_KEYWORD_LENGTH : KW_ROM_LEN;

    logic [KW_ROM_LEN*8-1:0] key;
    logic [NUM_KEYWORDS-1:0] eq;

    // Upper-cased name, zero beyond its length; ROM entries are zero padded.
    always_comb begin
        key = '0;
        for (int j = 0; j < CMP; j++) begin
            if (16'(j) < name_len) key[j*8 +: 8] = to_upper(name_chars[j*8 +: 8]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            eq[i] = (kw_rom(7'(i)) == key) && (name_len <= 16'(KW_ROM_LEN));
        end
        hit = 1'b0;
        index = '0;
        for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
            if (eq[i]) begin
                hit = 1'b1;
                index = 7'(i);
            end
        end
    end
endmodule

@@ rtl/core/blt_out_queue.sv @@
// Four-entry result queue with tlast: decouples the lexer from the result channel.
`timescale 1ns / 1ps
module blt_out_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_cnt,
    input  blt_pkg::token_t push_a,
    input  blt_pkg::token_t push_b,
    output logic            can_take,
    output logic            m_valid,
    input  logic            m_ready,
    output blt_pkg::token_t m_tok,
    output logic            m_last
);
    import blt_pkg::*;
    token_t q_reg [4];
    logic   l_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic pop;

    assign m_valid = cnt_reg != 3'd0;
    assign pop = m_valid && m_ready;
    assign m_tok = q_reg[rd_reg];
    assign m_last = l_reg[rd_reg];
    // Room for a worst-case two results from the beat accepted this cycle.
    assign can_take = cnt_reg <= 3'd2;

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_reg] <= push_a;
            l_reg[wr_reg] <= push_cnt == 2'd1;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_reg + 2'd1] <= push_b;
            l_reg[wr_reg + 2'd1] <= 1'b1;
        end
        if (!aresetn) begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_reg + push_cnt;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, push_cnt} - {2'b0, pop};
        end
    end
endmodule

@@ rtl/core/basic_lexical_tokenizer.sv @@
// Top level: BASIC lexer state machine, keyword match and result queue.
// Throughput: one character beat per cycle while the queue has room (s_tready);
//   each beat yields 0, 1 or 2 results, so the sustained rate is set by the
//   result port draining one token a cycle from the registered queue.
// Reset: aresetn low (synchronous) returns the lexer to idle and empties the queue.
`timescale 1ns / 1ps
`include "basic_lexical_tokenizer_assert.svh"
module basic_lexical_tokenizer #(
    parameter int MAX_KEYWORD_LENGTH = blt_pkg::MAX_KEYWORD_LENGTH_DEF,
    parameter int POSITION_WIDTH = blt_pkg::POSITION_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [23:8] line_number, [39:24] column_number
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] token_kind, [10:4] keyword_index, [15:11] symbol_index,
    // [17:16] error_code, [33:18] start_line, [49:34] start_column,
    // [65:50] token_length, [71:66] zero
    output logic [71:0] m_tdata,
    output logic        m_tlast
);
    import blt_pkg::*;
    localparam int PW = (POSITION_WIDTH < 16) ? POSITION_WIDTH : 16;

    mode_t mode_reg, mode_next;
    logic [MAX_KEYWORD_LENGTH*8-1:0] kbuf_reg, kbuf_next;
    logic [15:0] len_reg, len_next, sline_reg, sline_next, scol_reg, scol_next;
    logic [7:0] first_reg, first_next;

    logic [7:0] c;
    logic [15:0] line, col, len_grow;
    logic acc, kw_hit;
    logic [6:0] kw_idx;
    logic [MAX_KEYWORD_LENGTH*8-1:0] kw_chars;
    logic [15:0] kw_len;
    logic [1:0] n;
    token_t ta, tb, t_open, t_new;
    logic new_out, reopen;
    token_t m_tok;

    assign c = s_tdata[7:0];
    assign line = {{(16-PW){1'b0}}, s_tdata[8 +: PW]};
    assign col = {{(16-PW){1'b0}}, s_tdata[24 +: PW]};
    assign acc = s_tvalid && s_tready;
    assign len_grow = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;

    // Name seen by the keyword lookup: includes this character when it extends
    // the name, otherwise the name as it stood before this beat.
    always_comb begin
        kw_chars = kbuf_reg;
        kw_len = len_reg;
        if (is_alpha(c) || is_digit(c) || c == 8'h5F || is_suffix(c)) begin
            for (int j = 0; j < MAX_KEYWORD_LENGTH; j++) begin
                if (len_reg == 16'(j)) kw_chars[j*8 +: 8] = c;
            end
            kw_len = len_grow;
        end
    end

    blt_kw_match #(.MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH)) u_kw (
        .name_chars(kw_chars), .name_len(kw_len), .hit(kw_hit), .index(kw_idx)
    );

    always_comb begin
        mode_next = mode_reg;
        kbuf_next = kbuf_reg;
        len_next = len_reg;
        sline_next = sline_reg;
        scol_next = scol_reg;
        first_next = first_reg;
        n = 2'd0;
        reopen = 1'b0;
        t_open = '{kind: K_INT, kw: 7'd0, sym: 5'd0, err: E_NONE,
                   line: sline_reg, col: scol_reg, len: len_reg};
        t_new = '{kind: K_END, kw: 7'd0, sym: 5'd0, err: E_NONE,
                  line: line, col: col, len: 16'd1};
        new_out = 1'b0;
        case (mode_reg)
            M_WS: begin
                if (c == 8'h20 || c == 8'h09) len_next = len_grow;
                else reopen = 1'b1;
            end
            M_COMMENT: begin
                if (c != 8'h0A && c != 8'h00) len_next = len_grow;
                else reopen = 1'b1;
            end
            M_INT: begin
                if (is_digit(c)) len_next = len_grow;
                else if (c == 8'h2E) begin
                    mode_next = M_REAL;
                    len_next = len_grow;
                end else begin
                    n = 2'd1;
                    reopen = 1'b1;
                end
            end
            M_REAL: begin
                if (is_digit(c)) len_next = len_grow;
                else begin
                    n = 2'd1;
                    reopen = 1'b1;
                    if (first_reg == 8'h2E && len_reg == 16'd1) begin
                        t_open.kind = K_SYM;
                        t_open.sym = S_DOT;
                    end else t_open.kind = K_REAL;
                end
            end
            M_STR: begin
                t_open.kind = K_ERR;
                if (c == 8'h00) begin
                    t_open.err = E_UNTERM;
                    n = 2'd1;
                    reopen = 1'b1;
                end else if (c == 8'h0A) begin
                    t_open.err = E_NEWLINE;
                    n = 2'd1;
                    mode_next = M_IDLE;
                end else if (c == 8'h22) begin
                    len_next = len_grow;
                    t_open.kind = K_STR;
                    t_open.len = len_grow;
                    n = 2'd1;
                    mode_next = M_IDLE;
                end else len_next = len_grow;
            end
            M_NAME: begin
                t_open.kind = K_UNTYPED;
                if (is_alpha(c) || is_digit(c) || c == 8'h5F || is_suffix(c)) begin
                    for (int j = 0; j < MAX_KEYWORD_LENGTH; j++) begin
                        if (len_reg == 16'(j)) kbuf_next[j*8 +: 8] = c;
                    end
                    len_next = len_grow;
                    if (is_suffix(c)) begin
                        mode_next = M_IDLE;
                        n = 2'd1;
                        t_open.kind = K_TYPED;
                        t_open.len = len_grow;
                    end
                end else begin
                    n = 2'd1;
                    reopen = 1'b1;
                end
                if (kw_hit) begin
                    t_open.kind = K_KEY;
                    t_open.kw = kw_idx;
                end
            end
            M_SYM: begin
                t_open.kind = K_SYM;
                n = 2'd1;
                if (first_reg == 8'h3C && (c == 8'h3D || c == 8'h3E)) begin
                    t_open.sym = (c == 8'h3D) ? S_LE : S_NE;
                    t_open.len = len_grow;
                    mode_next = M_IDLE;
                end else if (first_reg == 8'h3E && c == 8'h3D) begin
                    t_open.sym = S_GE;
                    t_open.len = len_grow;
                    mode_next = M_IDLE;
                end else begin
                    t_open.sym = single_symbol(first_reg);
                    reopen = 1'b1;
                end
            end
            default: reopen = 1'b1;
        endcase

        // Start a new token with this character.
        if (reopen) begin
            mode_next = M_IDLE;
            sline_next = line;
            scol_next = col;
            len_next = 16'd1;
            first_next = c;
            if (c == 8'h00) begin
                new_out = 1'b1;
                t_new.len = 16'd0;
            end else if (c == 8'h20 || c == 8'h09) mode_next = M_WS;
            else if (c == 8'h27) mode_next = M_COMMENT;
            else if (is_alpha(c)) begin
                mode_next = M_NAME;
                kbuf_next[7:0] = c;
            end else if (is_digit(c)) mode_next = M_INT;
            else if (c == 8'h2E) mode_next = M_REAL;
            else if (c == 8'h0A) begin
                new_out = 1'b1;
                t_new.kind = K_EOL;
            end else if (c == 8'h22) mode_next = M_STR;
            else if (c == 8'h3C || c == 8'h3E) mode_next = M_SYM;
            else if (single_symbol(c) != S_NONE) begin
                new_out = 1'b1;
                t_new.kind = K_SYM;
                t_new.sym = single_symbol(c);
            end else begin
                new_out = 1'b1;
                t_new.kind = K_ERR;
                t_new.err = E_CHAR;
            end
        end
        ta = (n != 2'd0) ? t_open : t_new;
        tb = t_new;
        n = n + {1'b0, new_out};
        if (!acc) n = 2'd0;
    end

    // Token state only moves on an accepted character beat.
    always_ff @(posedge aclk) begin
        if (acc) begin
            kbuf_reg <= kbuf_next;
            len_reg <= len_next;
            sline_reg <= sline_next;
            scol_reg <= scol_next;
            first_reg <= first_next;
        end
        if (!aresetn) begin
            mode_reg <= M_IDLE;
        end else if (acc) begin
            mode_reg <= mode_next;
        end
    end

    blt_out_queue u_q (
        .aclk(aclk), .aresetn(aresetn), .push_cnt(n), .push_a(ta), .push_b(tb),
        .can_take(s_tready), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_tok(m_tok), .m_last(m_tlast)
    );

    assign m_tdata = {6'd0, m_tok.len, m_tok.col, m_tok.line, m_tok.err,
                      m_tok.sym, m_tok.kw, m_tok.kind};

    `BLT_ASSERT_IMP(a_kind_range, aclk, aresetn, m_tvalid, m_tdata[3:0] <= K_ERR,
        "token kind out of range")
    `BLT_ASSERT_IMP(a_err_kind, aclk, aresetn, m_tvalid && m_tdata[17:16] != E_NONE,
        m_tdata[3:0] == K_ERR, "error code on non-error token")
    `BLT_ASSERT_NEXT(a_end_last, aclk, aresetn, acc && s_tdata[7:0] == 8'h00,
        m_tvalid, "end byte gave no result")
endmodule

@@ tb/sv/basic_lexical_tokenizer_tb.sv @@
// Self-checking testbench for the BASIC lexical tokenizer stream block.
`timescale 1ns / 1ps
module basic_lexical_tokenizer_tb;
    import blt_pkg::*;

    // symbol positions in table order
    localparam logic [4:0] SY_PLUS = 5'd0, SY_MINUS = 5'd1, SY_STAR = 5'd2, SY_SLASH = 5'd3;
    localparam logic [4:0] SY_BSLASH = 5'd4, SY_LESS = 5'd5, SY_LESSEQ = 5'd6;
    localparam logic [4:0] SY_MORE = 5'd7, SY_MOREEQ = 5'd8, SY_EQ = 5'd9, SY_NOTEQ = 5'd10;
    localparam logic [4:0] SY_COLON = 5'd11, SY_COMMA = 5'd12, SY_SEMI = 5'd13;
    localparam logic [4:0] SY_LPAREN = 5'd14, SY_RPAREN = 5'd15, SY_PERIOD = 5'd16;
    localparam logic [4:0] SY_NOTONE = 5'd31;
    localparam int KW_MAXLEN = 9;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [3:0]  kind;
        logic [6:0]  kw;
        logic [4:0]  sym;
        logic [1:0]  err;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } token_rec_t;

    string keyword_names [87] = '{
        "ABS", "AND", "AS", "ASC", "ATN", "BIN$", "BOOLEAN", "CALL", "CASE",
        "CHR$", "COMMAND$", "CONST", "COS", "DATA", "DATE$", "DECLARE", "DIM",
        "DO", "ELSE", "ELSEIF", "END", "ENVIRON$", "EXIT", "EXP", "FALSE", "FIX",
        "FOR", "FUNCTION", "GOSUB", "HEX$", "IF", "INKEY$", "INPUT", "INSTR",
        "INT", "INTEGER", "IS", "LBOUND", "LCASE$", "LEFT$", "LEN", "LOG", "LOOP",
        "LTRIM$", "MID$", "MOD", "NEXT", "NOT", "OCT$", "OR", "PRINT",
        "RANDOMIZE", "READ", "REAL", "REDIM", "RESTORE", "RETURN", "RIGHT$",
        "RND", "RTRIM$", "SELECT", "SHARED", "SGN", "SIN", "SLEEP", "SPACE$",
        "SQR", "STATIC", "STEP", "STR$", "STRING", "STRING$", "SUB", "SWAP",
        "TAN", "TIME$", "TIMER", "THEN", "TO", "TRUE", "TYPE", "UBOUND",
        "UCASE$", "UNTIL", "VAL", "WHILE", "XOR"
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    basic_lexical_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // lexer shadow state
    mode_t       lex_mode;
    logic [7:0]  name_chars [KW_MAXLEN];
    logic [15:0] tok_len;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [7:0]  tok_first;

    token_rec_t  expected_tokens [$];
    int          mismatches;
    int          beats_sent;
    int          stall_count;
    bit          gaps_on;
    bit          timed_out;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit suffix_c(input logic [7:0] c);
        return c == "?" || c == "%" || c == "!" || c == "$";
    endfunction

    function automatic logic [4:0] symbol_of(input logic [7:0] c);
        case (c)
            "+": return SY_PLUS;    "-": return SY_MINUS;
            "*": return SY_STAR;    "/": return SY_SLASH;
            "\\": return SY_BSLASH; "<": return SY_LESS;
            ">": return SY_MORE;    "=": return SY_EQ;
            ":": return SY_COLON;   ",": return SY_COMMA;
            ";": return SY_SEMI;    "(": return SY_LPAREN;
            ")": return SY_RPAREN;  ".": return SY_PERIOD;
            default: return SY_NOTONE;
        endcase
    endfunction

    function automatic void push_token(input logic [3:0] kind, input logic [6:0] kw,
                                       input logic [4:0] sym, input logic [1:0] err,
                                       input logic [15:0] line, input logic [15:0] col,
                                       input logic [15:0] len);
        token_rec_t t;
        t.kind = kind; t.kw = kw; t.sym = sym; t.err = err;
        t.line = line; t.col = col; t.len = len; t.last = 1'b0;
        expected_tokens = {expected_tokens, t};
    endfunction

    function automatic void push_open(input logic [3:0] kind, input logic [6:0] kw,
                                      input logic [4:0] sym, input logic [1:0] err);
        push_token(kind, kw, sym, err, tok_line, tok_col, tok_len);
    endfunction

    function automatic void grow_token();
        if (tok_len != 16'hFFFF) tok_len++;
    endfunction

    // case-blind match of the open name against the keyword list
    function automatic int keyword_match();
        logic [7:0] b;
        bit ok;
        if (tok_len > KW_MAXLEN) return -1;
        for (int i = 0; i < 87; i++) begin
            ok = keyword_names[i].len() == tok_len;
            for (int j = 0; ok && j < tok_len; j++) begin
                b = name_chars[j];
                if (b >= "a" && b <= "z") b = b - 8'd32;
                if (keyword_names[i][j] != b) ok = 1'b0;
            end
            if (ok) return i;
        end
        return -1;
    endfunction

    function automatic void push_name(input bit typed);
        int k;
        k = keyword_match();
        if (k >= 0) push_open(K_KEY, k[6:0], 5'd0, E_NONE);
        else push_open(typed ? K_TYPED : K_UNTYPED, 7'd0, 5'd0, E_NONE);
    endfunction

    function automatic void mark_last(input int n);
        if (n > 0) expected_tokens[$].last = 1'b1;
    endfunction

    // expected tokens for one accepted character beat
    function automatic void predict_tokens(input logic [7:0] c, input logic [15:0] line,
                                           input logic [15:0] col);
        int n;
        logic [4:0] s;
        n = 0;
        case (lex_mode)
            M_WS: if (c == " " || c == "\t") begin grow_token(); return; end
            M_COMMENT: if (c != "\n" && c != 8'd0) begin grow_token(); return; end
            M_INT: begin
                if (digit_c(c)) begin grow_token(); return; end
                if (c == ".") begin lex_mode = M_REAL; grow_token(); return; end
                push_open(K_INT, 7'd0, 5'd0, E_NONE); n++;
            end
            M_REAL: begin
                if (digit_c(c)) begin grow_token(); return; end
                if (tok_first == "." && tok_len == 16'd1)
                    push_open(K_SYM, 7'd0, SY_PERIOD, E_NONE);
                else
                    push_open(K_REAL, 7'd0, 5'd0, E_NONE);
                n++;
            end
            M_STR: begin
                if (c == 8'd0) begin
                    push_open(K_ERR, 7'd0, 5'd0, E_UNTERM); n++;
                end else if (c == "\n") begin
                    lex_mode = M_IDLE;
                    push_open(K_ERR, 7'd0, 5'd0, E_NEWLINE); mark_last(1);
                    return;
                end else if (c == "\"") begin
                    lex_mode = M_IDLE;
                    grow_token();
                    push_open(K_STR, 7'd0, 5'd0, E_NONE); mark_last(1);
                    return;
                end else begin
                    grow_token();
                    return;
                end
            end
            M_NAME: begin
                if (alpha_c(c) || digit_c(c) || c == "_" || suffix_c(c)) begin
                    if (tok_len < KW_MAXLEN) name_chars[tok_len] = c;
                    grow_token();
                    if (!suffix_c(c)) return;
                    lex_mode = M_IDLE;
                    push_name(1'b1); mark_last(1);
                    return;
                end
                push_name(1'b0); n++;
            end
            M_SYM: begin
                if ((tok_first == "<" && (c == "=" || c == ">")) ||
                    (tok_first == ">" && c == "=")) begin
                    grow_token();
                    lex_mode = M_IDLE;
                    s = (tok_first == ">") ? SY_MOREEQ : (c == "=" ? SY_LESSEQ : SY_NOTEQ);
                    push_open(K_SYM, 7'd0, s, E_NONE); mark_last(1);
                    return;
                end
                push_open(K_SYM, 7'd0, symbol_of(tok_first), E_NONE); n++;
            end
            default: ;
        endcase

        // start a fresh token at this character
        lex_mode = M_IDLE;
        tok_line = line;
        tok_col = col;
        tok_len = 16'd1;
        tok_first = c;
        s = symbol_of(c);
        if (c == 8'd0) begin
            push_token(K_END, 7'd0, 5'd0, E_NONE, line, col, 16'd0); n++;
        end else if (c == " " || c == "\t") lex_mode = M_WS;
        else if (c == "'") lex_mode = M_COMMENT;
        else if (alpha_c(c)) begin
            lex_mode = M_NAME;
            name_chars[0] = c;
        end else if (digit_c(c)) lex_mode = M_INT;
        else if (c == ".") lex_mode = M_REAL;
        else if (c == "\n") begin
            push_token(K_EOL, 7'd0, 5'd0, E_NONE, line, col, 16'd1); n++;
        end else if (c == "\"") lex_mode = M_STR;
        else if (c == "<" || c == ">") lex_mode = M_SYM;
        else if (s != SY_NOTONE) begin
            push_token(K_SYM, 7'd0, s, E_NONE, line, col, 16'd1); n++;
        end else begin
            push_token(K_ERR, 7'd0, 5'd0, E_CHAR, line, col, 16'd1); n++;
        end
        mark_last(n);
    endfunction

    // one character beat; prediction happens once the beat is sure to go through
    task automatic send_char(input logic [7:0] c);
        logic [15:0] line;
        logic [15:0] col;
        int gap;
        line = 16'($urandom_range(0, 65535));
        col = 16'($urandom_range(0, 65535));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {col, line, c};
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_tready);
        predict_tokens(c, line, col);
        beats_sent++;
        @(posedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
    endtask

    // result sink with bursty back-pressure
    initial begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // check each token beat against the oldest expectation
    always @(negedge aclk) begin
        token_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token beat %h last %b", m_tdata, m_tlast);
            end else begin
                want = expected_tokens.pop_front();
                if (m_tdata[3:0] !== want.kind || m_tdata[10:4] !== want.kw ||
                    m_tdata[15:11] !== want.sym || m_tdata[17:16] !== want.err ||
                    m_tdata[33:18] !== want.line || m_tdata[49:34] !== want.col ||
                    m_tdata[65:50] !== want.len || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: want kind %0d kw %0d sym %0d err %0d ",
                                 want.kind, want.kw, want.sym, want.err,
                                 "line %0d col %0d len %0d last %b | ",
                                 want.line, want.col, want.len, want.last,
                                 "got kind %0d kw %0d sym %0d err %0d ",
                                 m_tdata[3:0], m_tdata[10:4], m_tdata[15:11],
                                 m_tdata[17:16],
                                 "line %0d col %0d len %0d last %b",
                                 m_tdata[33:18], m_tdata[49:34], m_tdata[65:50],
                                 m_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count = 0;
        else stall_count++;
        if (stall_count >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("basic_lexical_tokenizer_tb: FAIL");
            $finish;
        end
    end

    task automatic test_keywords();
        send_text("ABS rAnDoMiZe environ$ xor Xor% a_b? longername1 LONGERNAMES$ ");
        send_text("PRINT x! n% ");
        send_char(8'd0);
    endtask

    task automatic test_numbers_symbols();
        send_text("0 99.5 .25 . 7.x <> >= <= <a >b = + - * / \\ : , ; ( ) .");
        send_char(8'd0);
    endtask

    task automatic test_strings_errors();
        send_text("\"hi there\" 'note\n\"open\n_?!");
        send_char(8'hFF);
        send_char(8'h0D);
        send_char(8'h80);
        send_text("\t\"cut");
        send_char(8'd0);
        send_text("9");
        send_char(8'd0);
    endtask

    // long string, comment and blank run
    task automatic test_length_ceiling();
        send_char("\"");
        repeat (150) send_char("a");
        send_text("\"");
        send_text("'");
        repeat (60) send_char(" ");
        send_char("\n");
    endtask

    task automatic test_drain_pause();
        send_text("IF x THEN y");
        wait_drained();
        send_text(" ELSE z\n");
        wait_drained();
    endtask

    task automatic send_random_name(input bit as_keyword);
        string w;
        int n;
        if (as_keyword) w = keyword_names[$urandom_range(0, 86)];
        else begin
            n = $urandom_range(1, 12);
            w = "";
            for (int i = 0; i < n; i++)
                w = {w, string'(i > 0 && $urandom_range(0, 3) == 0 ?
                     8'("0" + $urandom_range(0, 9)) : 8'("A" + $urandom_range(0, 25)))};
            if ($urandom_range(0, 2) == 0) w = {w, string'(8'("$"))};
        end
        for (int i = 0; i < w.len(); i++) begin
            if (w[i] >= "A" && w[i] <= "Z" && $urandom_range(0, 1)) send_char(w[i] + 8'd32);
            else send_char(w[i]);
        end
    endtask

    task automatic test_random_stream(input int count);
        string syms;
        int pick;
        int base;
        syms = "+-*/\\<>=:,;().";
        base = beats_sent;
        while (beats_sent - base < count) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0, 1, 2: send_random_name(1'b1);
                3, 4: send_random_name(1'b0);
                5, 6: repeat ($urandom_range(1, 5)) send_char(8'("0" + $urandom_range(0, 9)));
                7: begin
                    repeat ($urandom_range(0, 3)) send_char(8'("0" + $urandom_range(0, 9)));
                    send_char(".");
                    repeat ($urandom_range(0, 3)) send_char(8'("0" + $urandom_range(0, 9)));
                end
                8: begin
                    send_char("\"");
                    repeat ($urandom_range(0, 6))
                        send_char($urandom_range(32, 126) == 34 ?
                                  8'd65 : 8'($urandom_range(32, 126)));
                    send_char($urandom_range(0, 7) == 0 ? 8'h0A : 8'h22);
                end
                9, 10, 11: send_char(syms[$urandom_range(0, syms.len() - 1)]);
                12, 13, 14:
                    repeat ($urandom_range(1, 3))
                        send_char($urandom_range(0, 1) ? " " : "\t");
                15: begin
                    send_char("'");
                    repeat ($urandom_range(0, 5)) send_char(8'($urandom_range(1, 255)));
                    send_char("\n");
                end
                16: send_char("\n");
                17: send_char(8'($urandom_range(1, 255)));
                18: send_char(8'($urandom_range(0, 255)));
                default: if ($urandom_range(0, 3) == 0) send_char(8'd0); else send_char(" ");
            endcase
        end
    endtask

    initial begin
        int waited;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        beats_sent = 0;
        stall_count = 0;
        gaps_on = 1'b1;
        timed_out = 1'b0;
        lex_mode = M_IDLE;
        tok_len = '0;
        tok_line = '0;
        tok_col = '0;
        tok_first = '0;
        foreach (name_chars[i]) name_chars[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_keywords();
        test_numbers_symbols();
        test_strings_errors();
        test_drain_pause();
        gaps_on = 1'b0;
        test_length_ceiling();
        gaps_on = 1'b1;
        test_random_stream(1000);
        gaps_on = 1'b0;
        test_random_stream(200);
        send_char(8'd0);
        s_tvalid <= 1'b0;

        waited = 0;
        while (expected_tokens.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("basic_lexical_tokenizer_tb: PASS");
        else
            $display("basic_lexical_tokenizer_tb: FAIL");
        $finish;
    end
endmodule

@@ basic_lexical_tokenizer.f @@
+incdir+rtl/core
rtl/core/blt_pkg.sv
rtl/core/blt_kw_match.sv
rtl/core/blt_out_queue.sv
rtl/core/basic_lexical_tokenizer.sv
tb/sv/basic_lexical_tokenizer_tb.sv
